/* rtl/core/hpid_pkg.sv */
`default_nettype none

package hpid_pkg;

	// Angles are Q4.12 radians, gains and drive are Q8.8.
	localparam logic signed [15:0] PI_Q     = 16'sd12868;
	localparam logic signed [15:0] TWO_PI_Q = 16'sd25736;

	// Product scaling: Q4.12 * Q8.8 gives Q12.20, drive is Q8.8.
	localparam int unsigned       PRODUCT_SHIFT = 12;
	localparam logic signed [49:0] ROUND_BIAS   = 50'sd2048;

	// Configuration register indexes.
	localparam logic [2:0] REG_GAIN_P   = 3'd0;
	localparam logic [2:0] REG_GAIN_I   = 3'd1;
	localparam logic [2:0] REG_GAIN_D   = 3'd2;
	localparam logic [2:0] REG_WINDOW   = 3'd3;
	localparam logic [2:0] REG_DEADBAND = 3'd4;
	localparam logic [2:0] REG_LIMIT    = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [15:0] RST_GAIN_P   = 16'd3328;
	localparam logic [15:0] RST_GAIN_I   = 16'd256;
	localparam logic [15:0] RST_GAIN_D   = 16'd2560;
	localparam logic [14:0] RST_WINDOW   = 15'd369;
	localparam logic [14:0] RST_DEADBAND = 15'd41;
	localparam logic [14:0] RST_LIMIT    = 15'd3072;

	typedef struct packed {
		logic [14:0] current_heading;
		logic [14:0] target_heading;
	} tick_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic               in_deadband;
	} cmd_t;

	typedef struct packed {
		logic [15:0] gain_proportional;
		logic [15:0] gain_integral;
		logic [15:0] gain_derivative;
		logic [14:0] integral_window;
		logic [14:0] deadband;
		logic [14:0] output_limit;
	} cfg_t;

	// Wrapped error and its window flags.
	typedef struct packed {
		logic signed [15:0] err;
		logic               in_window;
		logic               in_deadband;
	} err_t;

	// Weighted terms of one tick.
	typedef struct packed {
		logic signed [32:0] term_p;
		logic signed [48:0] term_i;
		logic signed [33:0] term_d;
		logic               in_deadband;
	} terms_t;

endpackage

`default_nettype wire

/* rtl/core/heading_pid_controller.sv */
`default_nettype none

// Channel  Dir  Handshake              Word
// tick     in   tick_valid/tick_stall  current_heading, target_heading (Q4.12)
// cmd      out  cmd_valid/cmd_stall    drive (Q8.8 signed), in_deadband
// cfg      in   cfg_write              cfg_index selects, cfg_data written
//
// cmd_valid rises after the tick has passed four registers in order: input
// register, wrapped error, weighted terms, output register. A new tick is
// taken every cycle while no cmd word stalls.
// arst_n clears all valids, the error history, the integral and loads the
// configuration registers with their defaults. A stalled cmd word freezes all
// four stages, and tick_stall follows until the word is taken.

module heading_pid_controller (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              tick_valid,
	output logic                   tick_stall,
	input  wire hpid_pkg::tick_t   tick,

	output logic                   cmd_valid,
	input  wire logic              cmd_stall,
	output hpid_pkg::cmd_t         cmd,

	input  wire logic              cfg_write,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);

	hpid_pkg::cfg_t   cfg_q;

	logic             adv;
	logic             vld_s1;
	hpid_pkg::tick_t  tick_s1;
	logic             vld_s2;
	hpid_pkg::err_t   err_s2;
	logic             vld_s3;
	hpid_pkg::terms_t terms_s3;

	// Advance every stage unless a finished word sits unclaimed.
	assign adv        = !(cmd_valid && cmd_stall);
	assign tick_stall = !adv;

	// Configuration registers; writes beyond the last index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_proportional <= hpid_pkg::RST_GAIN_P;
			cfg_q.gain_integral     <= hpid_pkg::RST_GAIN_I;
			cfg_q.gain_derivative   <= hpid_pkg::RST_GAIN_D;
			cfg_q.integral_window   <= hpid_pkg::RST_WINDOW;
			cfg_q.deadband          <= hpid_pkg::RST_DEADBAND;
			cfg_q.output_limit      <= hpid_pkg::RST_LIMIT;
		end else if (cfg_write) begin
			case (cfg_index)
				hpid_pkg::REG_GAIN_P:   cfg_q.gain_proportional <= cfg_data;
				hpid_pkg::REG_GAIN_I:   cfg_q.gain_integral     <= cfg_data;
				hpid_pkg::REG_GAIN_D:   cfg_q.gain_derivative   <= cfg_data;
				hpid_pkg::REG_WINDOW:   cfg_q.integral_window   <= cfg_data[14:0];
				hpid_pkg::REG_DEADBAND: cfg_q.deadband          <= cfg_data[14:0];
				hpid_pkg::REG_LIMIT:    cfg_q.output_limit      <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Input register: capture the headings of an accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tick_valid) begin
			tick_s1 <= tick;
		end
	end

	// Wrap the heading error and flag window and deadband.
	hpid_error u_error (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_s1  (vld_s1),
		.tick_s1 (tick_s1),
		.cfg     (cfg_q),
		.vld_s2  (vld_s2),
		.err_s2  (err_s2)
	);

	// Update integral and error history, form the three weighted terms.
	hpid_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_s2   (vld_s2),
		.err_s2   (err_s2),
		.cfg      (cfg_q),
		.vld_s3   (vld_s3),
		.terms_s3 (terms_s3)
	);

	// Sum, round, clamp, apply deadband and hold the cmd word.
	hpid_output u_output (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_s3   (vld_s3),
		.terms_s3 (terms_s3),
		.cfg      (cfg_q),
		.vld_s4   (cmd_valid),
		.cmd_s4   (cmd)
	);

endmodule

`default_nettype wire

/* rtl/core/hpid_error.sv */
`default_nettype none

module hpid_error (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          vld_s1,
	input  wire hpid_pkg::tick_t tick_s1,
	input  wire hpid_pkg::cfg_t  cfg,
	output logic               vld_s2,
	output hpid_pkg::err_t     err_s2
);

	logic signed [15:0] diff;
	logic signed [15:0] wrapped;
	logic        [14:0] mag;
	hpid_pkg::err_t     err_d;

	always_comb begin
		diff = $signed({1'b0, tick_s1.current_heading}) -
			$signed({1'b0, tick_s1.target_heading});
		// Fold into (-pi, pi]; one add or subtract of 2*pi always suffices.
		if (diff > hpid_pkg::PI_Q) begin
			wrapped = diff - hpid_pkg::TWO_PI_Q;
		end else if (diff <= -hpid_pkg::PI_Q) begin
			wrapped = diff + hpid_pkg::TWO_PI_Q;
		end else begin
			wrapped = diff;
		end
		mag = wrapped[15] ? 15'(-wrapped) : wrapped[14:0];
		err_d.err         = wrapped;
		err_d.in_window   = mag < cfg.integral_window;
		err_d.in_deadband = mag < cfg.deadband;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			err_s2 <= err_d;
		end
	end

`ifndef SYNTHESIS
	a_err_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (err_s2.err <= hpid_pkg::PI_Q && err_s2.err > -hpid_pkg::PI_Q))
		else $error("wrapped error outside (-pi, pi]");
`endif

endmodule

`default_nettype wire

/* rtl/core/hpid_state.sv */
`default_nettype none

module hpid_state (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          vld_s2,
	input  wire hpid_pkg::err_t err_s2,
	input  wire hpid_pkg::cfg_t cfg,
	output logic               vld_s3,
	output hpid_pkg::terms_t   terms_s3
);

	logic signed [15:0] prev_err_q;
	logic signed [31:0] integ_q;

	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_sat;
	logic signed [31:0] integ_next;
	logic signed [16:0] deriv;
	logic               sign_flip;
	hpid_pkg::terms_t   terms_d;

	always_comb begin
		sum_wide = $signed({integ_q[31], integ_q}) +
			$signed({{17{err_s2.err[15]}}, err_s2.err});
		if (sum_wide[32] != sum_wide[31]) begin
			sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sum_sat = sum_wide[31:0];
		end
		// Strictly opposite signs; zero on either side is no flip.
		sign_flip = (err_s2.err < 0 && prev_err_q > 0) ||
			(err_s2.err > 0 && prev_err_q < 0);
		integ_next = (err_s2.in_window && !sign_flip) ? sum_sat : 32'sd0;
		deriv = $signed({err_s2.err[15], err_s2.err}) -
			$signed({prev_err_q[15], prev_err_q});

		terms_d.term_p = $signed({{17{err_s2.err[15]}}, err_s2.err}) *
			$signed({17'b0, cfg.gain_proportional});
		terms_d.term_i = $signed({{17{integ_next[31]}}, integ_next}) *
			$signed({33'b0, cfg.gain_integral});
		terms_d.term_d = $signed({{17{deriv[16]}}, deriv}) *
			$signed({18'b0, cfg.gain_derivative});
		terms_d.in_deadband = err_s2.in_deadband;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3     <= 1'b0;
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
			if (vld_s2) begin
				prev_err_q <= err_s2.err;
				integ_q    <= integ_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s2) begin
			terms_s3 <= terms_d;
		end
	end

`ifndef SYNTHESIS
	a_flip_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s2 && sign_flip) |=> integ_q == 32'sd0)
		else $error("integral not cleared on error sign change");

	a_window_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s2 && !err_s2.in_window) |=> integ_q == 32'sd0)
		else $error("integral not cleared outside window");

	a_prev_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s2) |=> prev_err_q == $past(err_s2.err))
		else $error("previous error not updated");
`endif

endmodule

`default_nettype wire

/* rtl/core/hpid_output.sv */
`default_nettype none

module hpid_output (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          vld_s3,
	input  wire hpid_pkg::terms_t terms_s3,
	input  wire hpid_pkg::cfg_t   cfg,
	output logic               vld_s4,
	output hpid_pkg::cmd_t     cmd_s4
);

	logic signed [49:0] acc;
	logic signed [37:0] scaled;
	logic signed [37:0] lim_pos;
	logic signed [37:0] lim_neg;
	logic signed [37:0] clamped;
	hpid_pkg::cmd_t     cmd_d;

	always_comb begin
		acc = $signed({{17{terms_s3.term_p[32]}}, terms_s3.term_p}) +
			$signed({terms_s3.term_i[48], terms_s3.term_i}) +
			$signed({{16{terms_s3.term_d[33]}}, terms_s3.term_d}) +
			hpid_pkg::ROUND_BIAS;
		// Floor shift after the half bias: round to nearest, ties up.
		scaled  = acc[49:hpid_pkg::PRODUCT_SHIFT];
		lim_pos = $signed({23'b0, cfg.output_limit});
		lim_neg = -lim_pos;
		if (scaled > lim_pos) begin
			clamped = lim_pos;
		end else if (scaled < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = scaled;
		end
		cmd_d.in_deadband = terms_s3.in_deadband;
		cmd_d.drive       = terms_s3.in_deadband ? 16'sd0 : clamped[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s3) begin
			cmd_s4 <= cmd_d;
		end
	end

`ifndef SYNTHESIS
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && cmd_s4.in_deadband) |-> cmd_s4.drive == 16'sd0)
		else $error("drive not zero inside deadband");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Self-checking bench for the heading PID block.
	// A behavioral predictor mirrors the wrapped error, the windowed integral, the
	// derivative and the weighted, rounded and clamped drive. Each accepted tick
	// word pushes its expected cmd word onto a queue; a checker process compares
	// every accepted cmd word against the oldest entry.

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 7;
	localparam int SETTLE_CYCLES  = 12;           // four pipeline stages, with margin
	localparam int TIMEOUT_CYCLES = 2_000_000;
	localparam int CHUNK_TICKS    = 60;           // ticks per random register setting

	// Q4.12 heading constants: pi, 2*pi and the top of the legal range.
	localparam int HALF_TURN   = 12868;
	localparam int FULL_TURN   = 25736;
	localparam int HEADING_MAX = 25735;
	localparam int FIELD_MAX   = 32767;

	// Q4.12 * Q8.8 products are scaled back to Q8.8 by this shift.
	localparam int     FRAC_BITS  = 12;
	localparam longint ROUND_HALF = 2048;
	localparam longint SUM_MAX    = 64'sd2147483647;
	localparam longint SUM_MIN    = -64'sd2147483648;

	// Ticks held at each rail while the integral winds up.
	localparam int WINDUP_TICKS = 24;

	// Indexes past the register file; writes there must be ignored.
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef logic [15:0] reg_vals_t [6];

	logic            clk;
	logic            arst_n     = 1'b0;
	logic            tick_valid = 1'b0;
	logic            tick_stall;
	hpid_pkg::tick_t tick       = '0;
	logic            cmd_valid;
	logic            cmd_stall  = 1'b0;
	hpid_pkg::cmd_t  cmd;
	logic            cfg_write  = 1'b0;
	logic [2:0]      cfg_index  = '0;
	logic [15:0]     cfg_data   = '0;

	// Predictor state: register file copy, error history and integral.
	hpid_pkg::cfg_t     model_cfg;
	logic signed [15:0] last_err;
	logic signed [31:0] integ_sum;

	hpid_pkg::cmd_t drive_queue [$];
	bit   failed = 1'b0;
	int   send_idle_pct = 0;
	int   cmd_stall_pct = 0;

	heading_pid_controller dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
		$display("FAILURE");
		$finish;
	end

	// Advance the predictor by one tick and return the cmd word it must produce.
	function automatic hpid_pkg::cmd_t predict_cmd(input hpid_pkg::tick_t w);
		int             err;
		int             mag;
		int             deriv;
		longint         sum;
		longint         acc;
		longint         drv;
		longint         lim;
		bit             dead;
		hpid_pkg::cmd_t r;

		err = int'(w.current_heading) - int'(w.target_heading);
		// One fold by a full turn always lands a 15-bit difference in (-pi, pi].
		if (err > HALF_TURN)
			err -= FULL_TURN;
		else if (err <= -HALF_TURN)
			err += FULL_TURN;
		mag = (err < 0) ? -err : err;

		// Accumulate inside the window with saturation, clear outside it.
		if (mag < int'(model_cfg.integral_window)) begin
			sum = longint'(integ_sum) + err;
			if (sum > SUM_MAX)
				sum = SUM_MAX;
			if (sum < SUM_MIN)
				sum = SUM_MIN;
			integ_sum = sum[31:0];
		end else begin
			integ_sum = '0;
		end

		// A strict sign flip drops the integral; zero on either side does not.
		if ((err < 0 && last_err > 0) || (err > 0 && last_err < 0))
			integ_sum = '0;

		deriv    = err - int'(last_err);
		last_err = err[15:0];

		acc = longint'(err) * longint'(model_cfg.gain_proportional)
			+ longint'(integ_sum) * longint'(model_cfg.gain_integral)
			+ longint'(deriv) * longint'(model_cfg.gain_derivative);
		// Round to nearest, ties toward +inf: bias then floor shift.
		drv = (acc + ROUND_HALF) >>> FRAC_BITS;
		lim = longint'(model_cfg.output_limit);
		if (drv > lim)
			drv = lim;
		if (drv < -lim)
			drv = -lim;

		dead          = mag < int'(model_cfg.deadband);
		r.drive       = dead ? 16'sd0 : 16'(drv);
		r.in_deadband = dead;
		return r;
	endfunction

	// Check every accepted cmd word and pick the stall for the next cycle.
	// Values read here are the ones the block saw at this edge.
	always @(posedge clk) begin
		hpid_pkg::cmd_t want;
		if (cmd_valid === 1'b1 && cmd_stall == 1'b0) begin
			if (drive_queue.size() == 0) begin
				$display("%0t: unexpected cmd word drive=%0d in_deadband=%0b",
					$time, cmd.drive, cmd.in_deadband);
				failed = 1'b1;
			end else begin
				want = drive_queue.pop_front();
				if (cmd.drive !== want.drive) begin
					$display("%0t: drive mismatch expected %0d actual %0d",
						$time, want.drive, cmd.drive);
					failed = 1'b1;
				end
				if (cmd.in_deadband !== want.in_deadband) begin
					$display("%0t: in_deadband mismatch expected %0b actual %0b",
						$time, want.in_deadband, cmd.in_deadband);
					failed = 1'b1;
				end
			end
		end
		cmd_stall <= (cmd_stall_pct != 0) && ($urandom_range(99) < cmd_stall_pct);
	end

	// Hold reset once at the start and load the predictor's reset state.
	task automatic apply_reset();
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		model_cfg.gain_proportional = hpid_pkg::RST_GAIN_P;
		model_cfg.gain_integral     = hpid_pkg::RST_GAIN_I;
		model_cfg.gain_derivative   = hpid_pkg::RST_GAIN_D;
		model_cfg.integral_window   = hpid_pkg::RST_WINDOW;
		model_cfg.deadband          = hpid_pkg::RST_DEADBAND;
		model_cfg.output_limit      = hpid_pkg::RST_LIMIT;
		last_err  = '0;
		integ_sum = '0;
		@(posedge clk);
	endtask

	// Drop valid, wait for every expected word, then let the pipeline empty.
	task automatic settle();
		tick_valid <= 1'b0;
		while (drive_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all six registers, then both spare indexes, back to back.
	// Call only while the block is idle.
	task automatic program_regs(input reg_vals_t vals, input logic [15:0] spare_data);
		for (int i = int'(hpid_pkg::REG_GAIN_P); i <= hpid_pkg::REG_LIMIT; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			case (3'(i))
				hpid_pkg::REG_GAIN_P:   model_cfg.gain_proportional = vals[i];
				hpid_pkg::REG_GAIN_I:   model_cfg.gain_integral     = vals[i];
				hpid_pkg::REG_GAIN_D:   model_cfg.gain_derivative   = vals[i];
				hpid_pkg::REG_WINDOW:   model_cfg.integral_window   = vals[i][14:0];
				hpid_pkg::REG_DEADBAND: model_cfg.deadband          = vals[i][14:0];
				hpid_pkg::REG_LIMIT:    model_cfg.output_limit      = vals[i][14:0];
				default: ;
			endcase
		end
		cfg_write <= 1'b1;
		cfg_index <= REG_SPARE_LO;
		cfg_data  <= spare_data;
		@(posedge clk);
		cfg_index <= REG_SPARE_HI;
		cfg_data  <= ~spare_data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one tick word with a random lead-in gap; hold it until taken.
	// Valid stays high into the next call so back-to-back words need no toggle.
	task automatic send_tick(input int cur, input int tgt);
		hpid_pkg::tick_t w;
		w.current_heading = 15'(cur);
		w.target_heading  = 15'(tgt);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		tick       <= w;
		do
			@(posedge clk);
		while (tick_stall !== 1'b0);
		drive_queue.push_back(predict_cmd(w));
	endtask

	// A few ticks that hit pi, a small negative error, an out-of-range
	// heading and a tiny error under whatever setting is loaded.
	task automatic send_probe_ticks();
		send_tick(HALF_TURN, 0);
		send_tick(0, 100);
		send_tick(FIELD_MAX, 0);
		send_tick(3, 0);
	endtask

	// Wrap at +/-pi, out-of-range headings, window and deadband edges,
	// sign flips and zero error history, all at reset settings.
	task automatic test_heading_wrap_and_bands();
		send_tick(0, 0);                        // zero error inside deadband
		send_tick(HEADING_MAX, 0);              // wraps to -1
		send_tick(0, HEADING_MAX);              // wraps to +1
		send_tick(HALF_TURN, 0);                // exactly pi, kept
		send_tick(0, HALF_TURN);                // -pi folds to +pi
		send_tick(HALF_TURN + 1, 0);            // just past pi
		send_tick(0, HALF_TURN + 1);            // just past -pi
		send_tick(FIELD_MAX, 0);                // heading field beyond 2*pi
		send_tick(0, FIELD_MAX);
		send_tick(FIELD_MAX, FIELD_MAX);
		send_tick(368, 0);                      // just inside the window
		send_tick(368, 0);                      // integral grows
		send_tick(0, 368);                      // sign flip clears it
		send_tick(0, 369);                      // on the window edge: cleared
		send_tick(40, 0);                       // inside deadband after a flip
		send_tick(41, 0);                       // on the deadband edge
		send_tick(0, 40);
		send_tick(0, 0);
		send_tick(50, 0);                       // zero history is no flip
		send_tick(0, 41);
	endtask

	// All-low, all-high and masked register settings, plus spare indexes.
	task automatic test_register_extremes();
		reg_vals_t all_low  = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		reg_vals_t all_high = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		// Bit 15 set on the narrow registers must be masked off.
		reg_vals_t masked   = '{16'd1, 16'hFFFF, 16'd1, 16'h8000 | 16'd200,
			16'h8000, 16'h8000 | 16'd5};

		settle();
		program_regs(all_low, 16'hFFFF);
		send_probe_ticks();
		settle();
		program_regs(all_high, 16'h0000);
		send_probe_ticks();
		settle();
		program_regs(masked, 16'hA5A5);
		send_probe_ticks();
	endtask

	// Mostly convergence runs toward a held target, with overshoot so the
	// error crosses zero, the window and the deadband; the rest is noise.
	// Reload random registers every chunk.
	task automatic test_random_tracking(input int count);
		reg_vals_t vals;
		int        left;
		int        aim;
		int        off;
		int        cur;
		int        run;

		left = count;
		while (left > 0) begin
			settle();
			vals[hpid_pkg::REG_GAIN_P] = ($urandom_range(3) == 0)
				? 16'($urandom_range(16'hFFFF)) : 16'($urandom_range(4096));
			vals[hpid_pkg::REG_GAIN_I] = ($urandom_range(3) == 0)
				? 16'($urandom_range(16'hFFFF)) : 16'($urandom_range(1024));
			vals[hpid_pkg::REG_GAIN_D] = ($urandom_range(3) == 0)
				? 16'($urandom_range(16'hFFFF)) : 16'($urandom_range(4096));
			vals[hpid_pkg::REG_WINDOW] = ($urandom_range(4) == 0)
				? 16'($urandom_range(16'hFFFF)) : 16'($urandom_range(1500));
			vals[hpid_pkg::REG_DEADBAND] = ($urandom_range(4) == 0)
				? 16'($urandom_range(16'hFFFF)) : 16'($urandom_range(150));
			vals[hpid_pkg::REG_LIMIT] = 16'($urandom_range(16'hFFFF));
			program_regs(vals, 16'($urandom));

			for (int n = 0; n < CHUNK_TICKS && left > 0; ) begin
				if ($urandom_range(9) < 7) begin
					aim = $urandom_range(HEADING_MAX);
					off = int'($urandom_range(2 * HALF_TURN)) - HALF_TURN;
					run = $urandom_range(4, 24);
					for (int k = 0; k < run && left > 0; k++) begin
						cur = aim + off;
						if (cur < 0)
							cur += FULL_TURN;
						else if (cur >= FULL_TURN)
							cur -= FULL_TURN;
						send_tick(cur, aim);
						left--;
						n++;
						// Shrink the offset, sometimes past zero, plus jitter.
						off = off - (off * int'($urandom_range(2, 12))) / 8
							+ int'($urandom_range(40)) - 20;
					end
				end else begin
					send_tick($urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX));
					left--;
					n++;
				end
			end
		end
	endtask

	// Wind the integral far up at +pi with the window wide open, flip to just
	// above -pi so it clears and winds down, then end on a small error.
	task automatic test_integral_windup();
		reg_vals_t vals = '{16'd3328, 16'd1, 16'd0, 16'h7FFF, 16'd0, 16'h7FFF};

		settle();
		program_regs(vals, 16'h0000);
		repeat (WINDUP_TICKS) send_tick(HALF_TURN, 0);
		repeat (WINDUP_TICKS) send_tick(0, HALF_TURN - 1);
		send_tick(7, 0);
	endtask

	initial begin
		apply_reset();

		// Busy sender, slow receiver.
		send_idle_pct = 23;
		cmd_stall_pct = 53;
		test_heading_wrap_and_bands();
		test_random_tracking(140);

		// Slow sender, quicker receiver.
		settle();
		send_idle_pct = 53;
		cmd_stall_pct = 23;
		test_register_extremes();
		test_random_tracking(140);

		// Full rate both ways.
		settle();
		send_idle_pct = 0;
		cmd_stall_pct = 0;
		test_random_tracking(140);
		test_integral_windup();

		// Drain and watch for stray words before reporting.
		settle();
		if (!failed)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/hpid_pkg.sv
rtl/core/hpid_error.sv
rtl/core/hpid_state.sv
rtl/core/hpid_output.sv
rtl/core/heading_pid_controller.sv
sim/tb.sv
